@@ rtl/mlpr_pkg.sv @@
// Package for the mount longest-prefix router: sizes, codes, item types
// and the ASCII case fold. Used by every module under rtl/.
`timescale 1ns / 1ps

package mlpr_pkg;

  // Table and path sizes
  localparam int MOUNT_SLOTS  = 8;
  localparam int MOUNT_CHARS  = 32;
  localparam int PATH_LEN_MAX = 1024;

  // Fixed field widths
  localparam int SLOT_W = 3;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 4;
  localparam int TAIL_W = 11;
  localparam int MIDX_W = 3;

  // Derived widths
  localparam int IDX_W    = (MOUNT_SLOTS > 1) ? $clog2(MOUNT_SLOTS) : 1;
  localparam int CPOS_W   = $clog2(MOUNT_CHARS);
  localparam int LEN_W    = $clog2(MOUNT_CHARS + 1);
  localparam int PLEN_W   = $clog2(PATH_LEN_MAX + 2);
  localparam int CMP_W    = (PLEN_W > LEN_W) ? PLEN_W : LEN_W;
  localparam int TCMP_W   = (PLEN_W > TAIL_W) ? PLEN_W : TAIL_W;
  localparam int SCMP_W   = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int CCMP_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  // Characters
  localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  // Configuration register indexes
  localparam logic [0:0] CFG_SLOTS_ACTIVE  = 1'b0;
  localparam logic [0:0] CFG_TAIL_CAPACITY = 1'b1;

  localparam logic [CNT_W-1:0]  SLOTS_ACTIVE_RST  = 4'd0;
  localparam logic [TAIL_W-1:0] TAIL_CAPACITY_RST = 11'd1025;

  typedef enum logic [1:0] {
    ST_ROUTED    = 2'd0,
    ST_NO_OWNER  = 2'd1,
    ST_TAIL_LONG = 2'd2,
    ST_PATH_LONG = 2'd3
  } status_t;

  // Input item
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [CHAR_W-1:0] char_byte;
    logic              last;
  } in_t;

  // Result item
  typedef struct packed {
    status_t           status;
    logic [MIDX_W-1:0] mount_index;
    logic [TAIL_W-1:0] tail_start;
    logic [TAIL_W-1:0] tail_bytes;
    logic              tail_is_root;
  } out_t;

  // Item as it travels down the cell chain
  typedef struct packed {
    logic              is_path;
    logic              act;       // item does anything at all
    logic              last;
    logic [CHAR_W-1:0] char_byte;
    logic [SLOT_W-1:0] slot;
    logic              ld_first;  // first byte of a load: slot goes invalid
    logic              ld_wr;     // byte fits the slot
    logic [CPOS_W-1:0] ld_pos;
    logic [LEN_W-1:0]  ld_len;    // final length, used on the last byte
    logic [PLEN_W-1:0] p;         // path byte position
    logic [PLEN_W-1:0] plen;      // path length so far, saturating
    logic              p_invalid;
    logic [LEN_W-1:0]  best_len;  // zero while no owner found
    logic [IDX_W-1:0]  best_idx;
  } chain_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

@@ rtl/mlpr_front.sv @@
// Entry stage of the router: load and path bookkeeping, annotates each item
// before it enters the cell chain. Depends on mlpr_pkg.
`timescale 1ns / 1ps

module mlpr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlpr_pkg::in_t    in_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mlpr_pkg::chain_t dn_item
);
  import mlpr_pkg::*;

  logic [LEN_W-1:0]  load_position;
  logic [LEN_W-1:0]  load_last_nonslash;
  logic              load_invalid;
  logic [PLEN_W-1:0] path_position;
  logic              path_invalid;

  logic              accept;
  logic              slot_ok;
  logic              not_slash;
  logic              l_first;
  logic              l_wr;
  logic              l_inv;
  logic [LEN_W-1:0]  l_lnn;
  logic [LEN_W-1:0]  l_len;
  logic              p_inv;
  logic [PLEN_W-1:0] p_plen;
  chain_t            item_next;

  assign in_ready = !dn_valid || dn_ready;
  assign accept   = in_valid && in_ready;

  // Per-byte load and path arithmetic
  always_comb begin
    slot_ok   = SCMP_W'(in_data.slot) < SCMP_W'(MOUNT_SLOTS);
    not_slash = in_data.char_byte != CH_SLASH;
    l_first   = load_position == '0;
    l_wr      = load_position < LEN_W'(MOUNT_CHARS);
    l_inv     = load_invalid || (l_first && not_slash) || !l_wr;
    l_lnn     = (l_wr && not_slash) ? load_position + 1'b1 : load_last_nonslash;
    if (l_inv) begin
      l_len = '0;
    end else if (l_lnn == '0) begin
      l_len = LEN_W'(1);
    end else begin
      l_len = l_lnn;
    end
    p_inv  = path_invalid || (path_position == '0 && not_slash);
    p_plen = (path_position <= PLEN_W'(PATH_LEN_MAX)) ? path_position + 1'b1
                                                        : path_position;
  end

  // Annotated item
  always_comb begin
    item_next.is_path   = in_data.mode;
    item_next.act       = in_data.mode || slot_ok;
    item_next.last      = in_data.last;
    item_next.char_byte = in_data.char_byte;
    item_next.slot      = in_data.slot;
    item_next.ld_first  = l_first;
    item_next.ld_wr     = l_wr;
    item_next.ld_pos    = load_position[CPOS_W-1:0];
    item_next.ld_len    = l_len;
    item_next.p         = path_position;
    item_next.plen      = p_plen;
    item_next.p_invalid = p_inv;
    item_next.best_len  = '0;
    item_next.best_idx  = '0;
  end

  // Bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_position      <= '0;
      load_last_nonslash <= '0;
      load_invalid       <= 1'b0;
      path_position      <= '0;
      path_invalid       <= 1'b0;
    end else if (accept) begin
      if (!in_data.mode) begin
        if (slot_ok) begin
          if (in_data.last) begin
            load_position      <= '0;
            load_last_nonslash <= '0;
            load_invalid       <= 1'b0;
          end else begin
            load_position      <= l_wr ? load_position + 1'b1 : load_position;
            load_last_nonslash <= l_lnn;
            load_invalid       <= l_inv;
          end
        end
      end else begin
        if (in_data.last) begin
          path_position <= '0;
          path_invalid  <= 1'b0;
        end else begin
          path_position <= p_plen;
          path_invalid  <= p_inv;
        end
      end
    end
  end

  // Output stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (accept) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dn_item <= item_next;
    end
  end

endmodule

@@ rtl/mlpr_cell.sv @@
// One lane of the router chain: holds one mount slot, compares path bytes
// against it and folds its candidacy into the running best. Depends on mlpr_pkg.
`timescale 1ns / 1ps

module mlpr_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mlpr_pkg::IDX_W-1:0] cell_idx,
  input  logic [mlpr_pkg::CNT_W-1:0] slots_active,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  mlpr_pkg::chain_t            up_item,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output mlpr_pkg::chain_t            dn_item
);
  import mlpr_pkg::*;

  logic [CHAR_W-1:0] chars [MOUNT_CHARS];
  logic [LEN_W-1:0]  mount_length;
  logic              matching;

  logic              xfer;
  logic              my_slot;
  logic              cmp_lane;
  logic [CMP_W-1:0]  p_ext;
  logic [CMP_W-1:0]  plen_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CHAR_W-1:0] stored;
  logic              miss;
  logic              match_new;
  logic              in_count;
  logic              candidate;
  chain_t            item_next;

  assign up_ready = !dn_valid || dn_ready;
  assign xfer     = up_valid && up_ready;

  // Lane compare and best-so-far update
  always_comb begin
    my_slot   = SCMP_W'(up_item.slot) == SCMP_W'(cell_idx);
    p_ext     = CMP_W'(up_item.p);
    plen_ext  = CMP_W'(up_item.plen);
    len_ext   = CMP_W'(mount_length);
    stored    = chars[up_item.p[CPOS_W-1:0]];
    cmp_lane  = (mount_length > LEN_W'(1)) &&
                (up_item.p < PLEN_W'(PATH_LEN_MAX));
    miss      = 1'b0;
    if (cmp_lane) begin
      if (p_ext < len_ext) begin
        miss = fold_case(up_item.char_byte) != fold_case(stored);
      end else if (p_ext == len_ext) begin
        miss = up_item.char_byte != CH_SLASH;
      end
    end
    match_new = matching && !miss;
    in_count  = CCMP_W'(cell_idx) < CCMP_W'(slots_active);
    candidate = up_item.is_path && up_item.last && in_count &&
                (mount_length != '0) &&
                ((mount_length == LEN_W'(1)) || (match_new && plen_ext >= len_ext));

    item_next = up_item;
    if (candidate && mount_length > up_item.best_len) begin
      item_next.best_len = mount_length;
      item_next.best_idx = cell_idx;
    end
  end

  // Slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      mount_length <= '0;
      matching     <= 1'b1;
    end else if (xfer && up_item.act) begin
      if (up_item.is_path) begin
        matching <= up_item.last ? 1'b1 : match_new;
      end else if (my_slot) begin
        if (up_item.last) begin
          mount_length <= up_item.ld_len;
        end else if (up_item.ld_first) begin
          mount_length <= '0;
        end
      end
    end
  end

  // Mount bytes, no reset
  always_ff @(posedge clk) begin
    if (xfer && up_item.act && !up_item.is_path && my_slot && up_item.ld_wr) begin
      chars[up_item.ld_pos] <= up_item.char_byte;
    end
  end

  // Stage register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (xfer) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      dn_item <= item_next;
    end
  end

endmodule

@@ rtl/mlpr_result.sv @@
// Final stage of the router: turns the chain's best match into status and
// tail fields and holds the result register. Depends on mlpr_pkg.
`timescale 1ns / 1ps

module mlpr_result (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mlpr_pkg::TAIL_W-1:0] tail_capacity,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  mlpr_pkg::chain_t             up_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mlpr_pkg::out_t               out_data
);
  import mlpr_pkg::*;

  logic              produces;
  logic              xfer;
  logic [LEN_W-1:0]  consume;
  logic [CMP_W-1:0]  consume_ext;
  logic [CMP_W-1:0]  plen_ext;
  logic [PLEN_W-1:0] rest;
  out_t              res;

  assign produces = up_item.is_path && up_item.last;
  assign up_ready = !up_valid || !produces || !out_valid || out_ready;
  assign xfer     = up_valid && up_ready;

  // Status and tail
  always_comb begin
    consume     = (up_item.best_len > LEN_W'(1)) ? up_item.best_len : '0;
    consume_ext = CMP_W'(consume);
    plen_ext    = CMP_W'(up_item.plen);
    rest        = up_item.plen - PLEN_W'(consume);
    res         = '0;
    res.status  = ST_ROUTED;
    if (up_item.plen > PLEN_W'(PATH_LEN_MAX)) begin
      res.status = ST_PATH_LONG;
    end else if (up_item.p_invalid || up_item.best_len == '0) begin
      res.status = ST_NO_OWNER;
    end else if (tail_capacity < TAIL_W'(2)) begin
      res.status = ST_TAIL_LONG;
    end else if (consume_ext >= plen_ext) begin
      // path equals its mount: tail is a single slash
      res.mount_index  = MIDX_W'(up_item.best_idx);
      res.tail_start   = TAIL_W'(up_item.plen);
      res.tail_bytes   = TAIL_W'(1);
      res.tail_is_root = 1'b1;
    end else if (TCMP_W'(rest) >= TCMP_W'(tail_capacity)) begin
      res.status = ST_TAIL_LONG;
    end else begin
      res.mount_index = MIDX_W'(up_item.best_idx);
      res.tail_start  = TAIL_W'(consume);
      res.tail_bytes  = TAIL_W'(rest);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xfer && produces) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && produces) begin
      out_data <= res;
    end
  end

endmodule

@@ rtl/mount_longest_prefix_router.sv @@
// Top level of the mount longest-prefix router: configuration registers and
// the chain front -> cells -> result. Depends on mlpr_pkg and all rtl modules.
//
//   channel  signals                         direction  moves
//   in       in_valid/in_ready/in_data       input      load or path byte item
//   out      out_valid/out_ready/out_data    output     routing result item
//   cfg      cfg_we/cfg_index/cfg_data       input      register write, no wait
//
// One item per cycle sustained while results are taken; every item walks the
// chain through the entry register, one register per cell, then the result
// register. Synchronous reset clears all slot lengths and lane flags at once;
// no clearing pass. A stalled result holds the last stage; earlier stages keep
// filling bubbles and then hold in turn, back to in_ready.
`timescale 1ns / 1ps

module mount_longest_prefix_router (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mlpr_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mlpr_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [mlpr_pkg::TAIL_W-1:0] cfg_data
);
  import mlpr_pkg::*;

  logic [CNT_W-1:0]     slots_active;
  logic [TAIL_W-1:0]    tail_capacity;

  logic [MOUNT_SLOTS:0] stg_valid;
  logic [MOUNT_SLOTS:0] stg_ready;
  chain_t               stg_item [MOUNT_SLOTS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_active  <= SLOTS_ACTIVE_RST;
      tail_capacity <= TAIL_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_ACTIVE:  slots_active  <= cfg_data[CNT_W-1:0];
        CFG_TAIL_CAPACITY: tail_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  mlpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_item  (stg_item[0])
  );

  // One cell per mount slot
  for (genvar g = 0; g < MOUNT_SLOTS; g++) begin : g_cell
    mlpr_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cell_idx     (IDX_W'(g)),
      .slots_active (slots_active),
      .up_valid     (stg_valid[g]),
      .up_ready     (stg_ready[g]),
      .up_item      (stg_item[g]),
      .dn_valid     (stg_valid[g+1]),
      .dn_ready     (stg_ready[g+1]),
      .dn_item      (stg_item[g+1])
    );
  end

  mlpr_result u_result (
    .clk           (clk),
    .rst           (rst),
    .tail_capacity (tail_capacity),
    .up_valid      (stg_valid[MOUNT_SLOTS]),
    .up_ready      (stg_ready[MOUNT_SLOTS]),
    .up_item       (stg_item[MOUNT_SLOTS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

@@ sim/tb_mount_longest_prefix_router.sv @@
// Testbench for mount_longest_prefix_router: loads mount tables, streams paths
// and checks every routing result against an in-bench table predictor.
// Depends on mlpr_pkg and the rtl/ sources only.
`timescale 1ns / 1ps

module tb_mount_longest_prefix_router;
  import mlpr_pkg::*;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_PATH   = 1'b1;
  localparam int   LATENCY     = MOUNT_SLOTS + 2;
  localparam int   SETTLE      = 4 * LATENCY;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   PHASE_ITEMS = 32;
  localparam int   PRINT_CAP   = 40;

  // Register settings of the random phases, extremes included
  localparam int PHASES = 8;
  localparam int PHASE_COUNT [PHASES] = '{8, 8, 3, 15, 0, 8, 6, 8};
  localparam int PHASE_CAP   [PHASES] = '{1025, 2, 12, 2047, 1025, 1, 0, 30};

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we    = 1'b0;
  logic [0:0]        cfg_index = CFG_SLOTS_ACTIVE;
  logic [TAIL_W-1:0] cfg_data  = '0;

  mount_longest_prefix_router dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  in_t  pending [$];
  out_t route_expect [$];
  logic [CHAR_W-1:0] mbuf [$];
  logic [CHAR_W-1:0] pbuf [$];
  logic [CHAR_W-1:0] gen_mount [MOUNT_SLOTS][$];
  logic [MOUNT_CHARS-1:0] gen_written [MOUNT_SLOTS];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_pushed  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int errors        = 0;
  int settings_used = 0;
  int cycle_cnt     = 0;
  int status_tally [4];

  // Predictor state: mount table, load and path stream, registers
  logic [CHAR_W-1:0] tbl_char [MOUNT_SLOTS][MOUNT_CHARS];
  logic [LEN_W-1:0]  tbl_len [MOUNT_SLOTS];
  logic [LEN_W-1:0]  ld_pos, ld_keep;
  logic              ld_bad;
  logic [TAIL_W-1:0] walk_pos;
  logic              walk_bad;
  logic              lane_ok [MOUNT_SLOTS];
  logic [CNT_W-1:0]  reg_count;
  logic [TAIL_W-1:0] reg_capacity;

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
  endfunction

  task automatic clear_walk();
    walk_pos = '0;
    walk_bad = 1'b0;
    for (int i = 0; i < MOUNT_SLOTS; i++) lane_ok[i] = 1'b1;
  endtask

  // Advance the predictor by one accepted item; a last path byte yields a result
  task automatic route_item(input in_t it);
    logic [TAIL_W-1:0] p, plen;
    logic [LEN_W-1:0]  len, best_len, consume;
    int                best, count;
    out_t              res;
    if (it.mode == MODE_LOAD) begin
      if (ld_pos == 0) begin
        tbl_len[it.slot] = '0;
        if (it.char_byte != CH_SLASH) ld_bad = 1'b1;
      end
      if (ld_pos < MOUNT_CHARS) begin
        tbl_char[it.slot][ld_pos[CPOS_W-1:0]] = it.char_byte;
        if (it.char_byte != CH_SLASH) ld_keep = ld_pos + 1'b1;
        ld_pos = ld_pos + 1'b1;
      end else begin
        ld_bad = 1'b1;
      end
      if (it.last) begin
        tbl_len[it.slot] = ld_bad ? '0 : ((ld_keep == 0) ? LEN_W'(1) : ld_keep);
        ld_pos  = '0;
        ld_keep = '0;
        ld_bad  = 1'b0;
      end
      return;
    end

    // Path byte: every lane compares against the table as it stands now
    p = walk_pos;
    if (p == 0 && it.char_byte != CH_SLASH) walk_bad = 1'b1;
    if (p < PATH_LEN_MAX) begin
      for (int i = 0; i < MOUNT_SLOTS; i++) begin
        len = tbl_len[i];
        if (len > 1) begin
          if (p < len) begin
            if (lower_ascii(it.char_byte) != lower_ascii(tbl_char[i][p[CPOS_W-1:0]]))
              lane_ok[i] = 1'b0;
          end else if (p == len && it.char_byte != CH_SLASH) begin
            lane_ok[i] = 1'b0;
          end
        end
      end
    end
    if (p <= PATH_LEN_MAX) walk_pos = p + 1'b1;
    if (!it.last) return;

    // Longest valid match below the count; ties keep the lower slot
    plen = walk_pos;
    count = (reg_count > MOUNT_SLOTS) ? MOUNT_SLOTS : reg_count;
    best = -1;
    best_len = '0;
    for (int i = 0; i < count; i++) begin
      len = tbl_len[i];
      if (len != 0 && (len == 1 || (lane_ok[i] && plen >= len)) && len > best_len) begin
        best = i;
        best_len = len;
      end
    end

    res = '0;
    if (plen > PATH_LEN_MAX) begin
      res.status = ST_PATH_LONG;
    end else if (walk_bad || best < 0) begin
      res.status = ST_NO_OWNER;
    end else begin
      consume = (best_len > 1) ? best_len : '0;
      if (reg_capacity < 2) begin
        res.status = ST_TAIL_LONG;
      end else if (consume >= plen) begin
        res.status       = ST_ROUTED;
        res.mount_index  = MIDX_W'(best);
        res.tail_start   = plen;
        res.tail_bytes   = TAIL_W'(1);
        res.tail_is_root = 1'b1;
      end else if (plen - consume >= reg_capacity) begin
        res.status = ST_TAIL_LONG;
      end else begin
        res.status      = ST_ROUTED;
        res.mount_index = MIDX_W'(best);
        res.tail_start  = TAIL_W'(consume);
        res.tail_bytes  = plen - consume;
      end
    end
    route_expect.push_back(res);
    status_tally[res.status]++;
    clear_walk();
  endtask

  // Driver: presents queued items, holds them until accepted
  always @(posedge clk) begin : feed_items
    in_t nxt;
    logic hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        route_item(in_data);
        items_taken++;
      end
      if (!hold) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH result %0d at %0t: %s", results_seen, $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Monitor: compares each accepted result with the oldest expectation
  always @(posedge clk) begin : watch_results
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (route_expect.size() == 0) begin
          flag("result arrived with no path outstanding");
        end else begin
          want = route_expect.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("mount_index", out_data.mount_index, want.mount_index);
          check_field("tail_start", out_data.tail_start, want.tail_start);
          check_field("tail_bytes", out_data.tail_bytes, want.tail_bytes);
          check_field("tail_is_root", out_data.tail_is_root, want.tail_is_root);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               route_expect.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic put_item(input logic mode, input logic [SLOT_W-1:0] s,
                          input logic [CHAR_W-1:0] c, input logic lst);
    in_t it;
    it.mode      = mode;
    it.slot      = s;
    it.char_byte = c;
    it.last      = lst;
    pending.push_back(it);
    items_pushed++;
  endtask

  task automatic load_byte_at(input logic [SLOT_W-1:0] s, input int i);
    put_item(MODE_LOAD, s, mbuf[i], i == mbuf.size() - 1);
    if (i < MOUNT_CHARS) gen_written[s][i] = 1'b1;
  endtask

  // Path items carry a random slot, which the block ignores
  task automatic path_byte_at(input int i);
    put_item(MODE_PATH, SLOT_W'($urandom_range(MOUNT_SLOTS - 1)), pbuf[i],
             i == pbuf.size() - 1);
  endtask

  // Remember well-formed mounts so that paths can be built to hit them
  task automatic note_mount(input logic [SLOT_W-1:0] s);
    if (mbuf.size() <= MOUNT_CHARS && mbuf[0] == CH_SLASH) gen_mount[s] = mbuf;
    else gen_mount[s].delete();
  endtask

  task automatic put_load(input logic [SLOT_W-1:0] s);
    for (int i = 0; i < mbuf.size(); i++) load_byte_at(s, i);
    note_mount(s);
  endtask

  task automatic put_path();
    for (int i = 0; i < pbuf.size(); i++) path_byte_at(i);
  endtask

  // One stream cut in two with the other stream placed whole in between
  task automatic put_mixed(input logic [SLOT_W-1:0] s, input logic path_outer);
    int cut;
    if (path_outer) begin
      cut = $urandom_range(pbuf.size() - 1);
      for (int i = 0; i < cut; i++) path_byte_at(i);
      put_load(s);
      for (int i = cut; i < pbuf.size(); i++) path_byte_at(i);
    end else begin
      cut = $urandom_range(mbuf.size() - 1);
      for (int i = 0; i < cut; i++) load_byte_at(s, i);
      put_path();
      for (int i = cut; i < mbuf.size(); i++) load_byte_at(s, i);
      note_mount(s);
    end
  endtask

  // Load whose last byte goes to another slot; only when that slot already
  // holds bytes at every position its new length can reach
  task automatic put_split_load(input logic [SLOT_W-1:0] a);
    logic [SLOT_W-1:0]      b;
    logic [MOUNT_CHARS-1:0] need;
    int                     n;
    n = mbuf.size();
    b = SLOT_W'($urandom_range(MOUNT_SLOTS - 1));
    need = '0;
    if (n >= 2 && n <= MOUNT_CHARS) need = (MOUNT_CHARS'(1) << (n - 1)) - 1'b1;
    if (n < 2 || (gen_written[b] & need) != need) begin
      put_load(a);
      return;
    end
    for (int i = 0; i < n - 1; i++) load_byte_at(a, i);
    load_byte_at(b, n - 1);
    gen_mount[a].delete();
    gen_mount[b].delete();
  endtask

  task automatic load_text(input logic [SLOT_W-1:0] s, input string t);
    mbuf.delete();
    for (int i = 0; i < t.len(); i++) mbuf.push_back(t[i]);
    put_load(s);
  endtask

  task automatic path_text(input string t);
    pbuf.delete();
    for (int i = 0; i < t.len(); i++) pbuf.push_back(t[i]);
    put_path();
  endtask

  // Small letter set so that random mounts often share prefixes
  function automatic logic [CHAR_W-1:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CHAR_W'(8'h61 + $urandom_range(3));   // a..d
    if (r < 65) return CHAR_W'(8'h41 + $urandom_range(3));   // A..D
    if (r < 75) return CHAR_W'(8'h30 + $urandom_range(9));   // digits
    if (r < 88) begin
      // neighbors of the letter ranges, which must not fold
      case ($urandom_range(3))
        0:       return 8'h40;
        1:       return 8'h5B;
        2:       return 8'h60;
        default: return 8'h7B;
      endcase
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] case_flip(input logic [CHAR_W-1:0] c);
    if (lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7A && $urandom_range(1))
      return c ^ CASE_OFFSET;
    return c;
  endfunction

  task automatic build_mount();
    int r, nseg;
    mbuf.delete();
    r = $urandom_range(99);
    mbuf.push_back((r < 6) ? rand_char() : CH_SLASH);
    // root forms: one or more slashes
    if (r >= 6 && r < 16) begin
      repeat ($urandom_range(2)) mbuf.push_back(CH_SLASH);
      return;
    end
    // many segments usually overflow the slot
    nseg = (r >= 16 && r < 24) ? 12 : $urandom_range(1, 3);
    for (int k = 0; k < nseg; k++) begin
      if (k > 0) mbuf.push_back(CH_SLASH);
      repeat ($urandom_range(1, 4)) mbuf.push_back(rand_char());
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) mbuf.push_back(CH_SLASH);
  endtask

  task automatic build_path();
    int r, s, keep;
    pbuf.delete();
    r = $urandom_range(99);
    s = $urandom_range(MOUNT_SLOTS - 1);
    if (r < 75 && gen_mount[s].size() != 0) begin
      for (int k = 0; k < gen_mount[s].size(); k++) pbuf.push_back(case_flip(gen_mount[s][k]));
      case ($urandom_range(4))
        0: ;  // path equals the mount
        1: begin
          pbuf.push_back(CH_SLASH);
          repeat ($urandom_range(1, 6)) pbuf.push_back(rand_char());
        end
        2: repeat ($urandom_range(1, 3)) pbuf.push_back(rand_char());  // off a boundary
        3: begin
          keep = $urandom_range(1, pbuf.size());
          while (pbuf.size() > keep) pbuf.delete(pbuf.size() - 1);
        end
        default: pbuf.push_back(CH_SLASH);
      endcase
    end else begin
      pbuf.push_back(CH_SLASH);
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(1, 4)) pbuf.push_back(rand_char());
        pbuf.push_back(CH_SLASH);
      end
      if (pbuf.size() > 1 && $urandom_range(1)) pbuf.delete(pbuf.size() - 1);
    end
    if ($urandom_range(19) == 0) pbuf[0] = rand_char();
  endtask

  task automatic random_phase(input int target);
    int first, r;
    first = items_pushed;
    while (items_pushed - first < target) begin
      r = $urandom_range(99);
      if (r < 22) begin
        build_mount();
        put_load(SLOT_W'($urandom_range(MOUNT_SLOTS - 1)));
      end else if (r < 78) begin
        build_path();
        put_path();
      end else if (r < 84) begin
        build_mount();
        put_split_load(SLOT_W'($urandom_range(MOUNT_SLOTS - 1)));
      end else if (r < 92) begin
        build_mount();
        build_path();
        put_mixed(SLOT_W'($urandom_range(MOUNT_SLOTS - 1)), 1'($urandom_range(1)));
      end else begin
        // raw noise bytes
        pbuf.delete();
        repeat ($urandom_range(1, 6)) pbuf.push_back(CHAR_W'($urandom_range(255)));
        put_path();
      end
    end
  endtask

  // Wait until every item is in and every result out, then let loads finish
  task automatic drain();
    while (items_taken != items_pushed || route_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= TAIL_W'(val);
    if (idx == CFG_SLOTS_ACTIVE) reg_count = CNT_W'(val);
    else reg_capacity = TAIL_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(input int count, input int cap, input int idle_mode);
    drain();
    write_reg(CFG_SLOTS_ACTIVE, count);
    write_reg(CFG_TAIL_CAPACITY, cap);
    settings_used++;
    case (idle_mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 66; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // ---------------- test sequence ----------------
  initial begin
    for (int i = 0; i < MOUNT_SLOTS; i++) begin
      tbl_len[i] = '0;
      gen_written[i] = '0;
      for (int k = 0; k < MOUNT_CHARS; k++) tbl_char[i][k] = '0;
    end
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    ld_pos = '0;
    ld_keep = '0;
    ld_bad = 1'b0;
    clear_walk();
    reg_count = SLOTS_ACTIVE_RST;
    reg_capacity = TAIL_CAPACITY_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: no slot takes part, so nothing is routed
    load_text(0, "/");
    load_text(1, "/usr");
    path_text("/usr/a");

    set_phase(MOUNT_SLOTS, 1025, 0);
    // Table with trailing slashes, a relative mount, an overflow, a tie,
    // a full-width mount and fold-boundary characters
    load_text(1, "/Usr//");
    load_text(2, "usr");
    mbuf.delete();
    mbuf.push_back(CH_SLASH);
    repeat (MOUNT_CHARS) mbuf.push_back(8'h61);
    put_load(3);
    load_text(4, "/usr/lib");
    load_text(5, "/USR");
    mbuf.delete();
    mbuf.push_back(CH_SLASH);
    repeat (MOUNT_CHARS - 1) mbuf.push_back(8'h62);
    put_load(6);
    load_text(7, "/@[");

    path_text("/usr/LIB/x");
    path_text("/uSr");
    path_text("/usrx");
    path_text("/`{");
    path_text("/@[");
    path_text("usr");
    path_text("/");
    pbuf.delete();
    pbuf.push_back(CH_SLASH);
    pbuf.push_back(8'hFF);
    pbuf.push_back(8'h00);
    put_path();
    pbuf.delete();
    pbuf.push_back(8'hFF);
    pbuf.push_back(CH_SLASH);
    put_path();
    // full-width mount, matched in the other case
    pbuf.delete();
    pbuf.push_back(CH_SLASH);
    repeat (MOUNT_CHARS - 1) pbuf.push_back(8'h42);
    pbuf.push_back(CH_SLASH);
    pbuf.push_back(8'h7A);
    put_path();
    // second root ties with slot 0
    load_text(2, "//");
    path_text("/q");

    // Loads interleaved with paths
    load_text(4, "/usr/lib");
    mbuf = {8'h2F, 8'h75, 8'h73, 8'h72, 8'h2F, 8'h6C, 8'h69};
    pbuf = {8'h2F, 8'h75, 8'h73, 8'h72, 8'h2F, 8'h6C, 8'h69, 8'h62, 8'h2F, 8'h71};
    put_mixed(4, MODE_LOAD);
    put_mixed(4, MODE_PATH);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_phase(PHASE_COUNT[ph], PHASE_CAP[ph], ph % 4);
      random_phase(PHASE_ITEMS);
    end

    drain();
    $display("Covered %0d items, %0d results over %0d register settings", items_taken,
             results_seen, settings_used);
    $display("Routed %0d, no owner %0d, tail too long %0d, path too long %0d; %0d mismatches",
             status_tally[ST_ROUTED], status_tally[ST_NO_OWNER],
             status_tally[ST_TAIL_LONG], status_tally[ST_PATH_LONG], errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mlpr_pkg.sv
rtl/mlpr_front.sv
rtl/mlpr_cell.sv
rtl/mlpr_result.sv
rtl/mount_longest_prefix_router.sv
sim/tb_mount_longest_prefix_router.sv
